// ===== design/lwgf_pkg.sv =====
// ----------------------------------------------------------------------------
// lwgf_pkg
// Shared types, constants and helpers for the longest ones span block.
// ----------------------------------------------------------------------------
package lwgf_pkg;

	localparam int SPAN_W    = 21;
	localparam int CFG_W     = 4;
	localparam int CFG_MAX   = 15;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = 3;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

	typedef logic [SPAN_W-1:0] span_t;

	// window check operands handed from the cell row to the span tracker
	typedef struct packed {
		logic  v1;
		logic  v2;
		logic  last;
		logic  zero2;
		logic  one2;
		span_t lc;
		span_t lp;
		span_t g1;
		span_t g2;
	} chk_op_t;

	function automatic span_t sat_add(span_t a, span_t b, span_t cap);
		logic [SPAN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = (s > {1'b0, cap}) ? cap : s[SPAN_W-1:0];
	endfunction

endpackage

// ===== design/lwgf_in_if.sv =====
// ----------------------------------------------------------------------------
// lwgf_in_if
// Input channel: one stream bit and its last flag per item.
// ----------------------------------------------------------------------------
interface lwgf_in_if;

	logic valid;
	logic ready;
	logic bit_value;
	logic is_last;

	modport source (output valid, output bit_value, output is_last, input ready);
	modport sink (input valid, input bit_value, input is_last, output ready);

endinterface

// ===== design/lwgf_out_if.sv =====
// ----------------------------------------------------------------------------
// lwgf_out_if
// Output channel: one longest span result per item.
// ----------------------------------------------------------------------------
interface lwgf_out_if import lwgf_pkg::*; ();

	logic  valid;
	logic  ready;
	span_t longest_span;

	modport source (output valid, output longest_span, input ready);
	modport sink (input valid, input longest_span, output ready);

endinterface

// ===== design/lwgf_cell.sv =====
// ----------------------------------------------------------------------------
// lwgf_cell
// One cell of the run row: holds the saturated sum of the most recent runs
// up to its place, and takes its neighbour's sum plus the new run on a push.
// ----------------------------------------------------------------------------
module lwgf_cell import lwgf_pkg::*; #(
	parameter span_t CAP = 21'h1FFFFF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  logic  clear,
	input  span_t run_len,
	input  span_t prev_sum,
	output span_t sum
);

	span_t sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
		end else if (push) begin
			sum_q <= sat_add(run_len, prev_sum, CAP);
		end
	end

	assign sum = sum_q;

endmodule

// ===== design/lwgf_best.sv =====
// ----------------------------------------------------------------------------
// lwgf_best
// Span tracker: forms the window sums, keeps the best one and hands the
// final value over at the end of each stream.
// ----------------------------------------------------------------------------
module lwgf_best import lwgf_pkg::*; #(
	parameter span_t CAP = 21'h1FFFFF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  chk_op_t op,
	output logic    push,
	output span_t   push_data
);

	span_t c1_s2;
	span_t c2_s2;
	logic  v1_s2;
	logic  v2_s2;
	logic  last_s2;
	span_t best_q;
	span_t best_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s2   <= 1'b0;
			v2_s2   <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v1_s2   <= op.v1;
			v2_s2   <= op.v2;
			last_s2 <= op.last;
		end
	end

	// window with an empty closing run and a single-run window are special
	always_ff @(posedge clk) begin
		c1_s2 <= sat_add(op.lc, op.g1, CAP);
		c2_s2 <= op.zero2 ? span_t'(op.one2) : sat_add(op.lp, op.g2, CAP);
	end

	always_comb begin
		best_nxt = best_q;
		if (v1_s2 && (c1_s2 > best_nxt)) begin
			best_nxt = c1_s2;
		end
		if (v2_s2 && (c2_s2 > best_nxt)) begin
			best_nxt = c2_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (last_s2) begin
			best_q <= '0;
		end else begin
			best_q <= best_nxt;
		end
	end

	assign push      = last_s2;
	assign push_data = best_nxt;

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		last_s2 |=> best_q == '0)
		else $error("best span not cleared after end of stream");

endmodule

// ===== design/lwgf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lwgf_out_fifo
// Small result queue in front of the output channel, with a registered head.
// ----------------------------------------------------------------------------
module lwgf_out_fifo import lwgf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  span_t       push_data,
	lwgf_out_if.source  out_ch
);

	localparam int PTR_W = $clog2(OUT_DEPTH);

	span_t                mem_q [OUT_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	span_t                head_q;
	logic                 head_v_q;
	logic                 pop;
	logic                 load;
	logic                 rd;
	logic                 wr;

	assign pop  = head_v_q && out_ch.ready;
	assign load = !head_v_q || pop;
	// with nothing queued and the head free or being taken, a new item goes straight into the head register
	assign rd   = load && (cnt_q != '0);
	assign wr   = push && !(load && (cnt_q == '0));

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= push_data;
		end
		if (load) begin
			head_q <= (cnt_q != '0) ? mem_q[rd_ptr_q] : push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			head_v_q <= 1'b0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + OUT_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OUT_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			if (load) begin
				head_v_q <= (cnt_q != '0) || push;
			end
		end
	end

	assign out_ch.valid        = head_v_q;
	assign out_ch.longest_span = head_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> cnt_q != OUT_CNT_W'(OUT_DEPTH))
		else $error("result queue written while full");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == $past(cnt_q) + OUT_CNT_W'(1))
		else $error("result queue count did not follow a write");

endmodule

// ===== design/longest_ones_with_gap_fills_top.sv =====
// ----------------------------------------------------------------------------
// longest_ones_with_gap_fills_top
// Longest span of ones in a bit stream with up to max_flips zero runs filled.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   bit_value, is_last
//  out_ch    out  valid/ready   longest_span (one per stream)
//  cfg       in   cfg_wr_en     cfg_wr_data -> max_flips
//
//  one bit is taken every cycle while in_ch.ready is high; each item updates the run counter and, on a
//  run change, shifts the run into the row of sum cells in the same cycle
//  a stream's result passes the registered tap select and window sums and the
//  best compare, then is offered on out_ch from the output queue's head register
//  in_ch.ready falls only while four ended streams still owe their result
//  arst_n clears all state but the window sum and queue data registers at once; max_flips resets to one
// ----------------------------------------------------------------------------
module longest_ones_with_gap_fills_top import lwgf_pkg::*; #(
	parameter int MAX_FLIPS         = 15,
	parameter int MAX_STREAM_LENGTH = 1048576
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	lwgf_in_if.sink          in_ch,
	lwgf_out_if.source       out_ch
);

	localparam span_t LEN_CAP = (MAX_STREAM_LENGTH < ((1 << SPAN_W) - 1)) ?
		span_t'(MAX_STREAM_LENGTH) : {SPAN_W{1'b1}};
	localparam int KMAX  = (MAX_FLIPS < CFG_MAX) ? MAX_FLIPS : CFG_MAX;
	localparam int NCELL = 2 * KMAX;

	logic [CFG_W-1:0]     max_flips_q;
	logic                 exp_q;
	span_t                len_q;
	logic [OUT_CNT_W-1:0] pend_q;

	logic                 acc;
	logic                 mismatch;
	logic                 cell_push;
	logic                 cell_clear;
	span_t                len_inc;
	logic [CFG_W-1:0]     k;
	logic [CFG_W:0]       w;
	logic [CFG_W+1:0]     wd1;
	logic [CFG_W+1:0]     wd2;
	logic [CFG_W+1:0]     wd3;
	span_t                g1;
	span_t                g2;
	span_t                g3;
	span_t                sums [NCELL];
	chk_op_t              op_s1;
	logic                 res_push;
	span_t                res_data;

	assign in_ch.ready = (pend_q != OUT_CNT_W'(OUT_DEPTH));
	assign acc         = in_ch.valid && in_ch.ready;
	assign mismatch    = (in_ch.bit_value != exp_q);
	assign len_inc     = (len_q < LEN_CAP) ? len_q + span_t'(1) : len_q;
	assign cell_push   = acc && mismatch && !in_ch.is_last;
	assign cell_clear  = acc && in_ch.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_flips_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			max_flips_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 1'b1;
			len_q <= '0;
		end else if (acc) begin
			if (in_ch.is_last) begin
				exp_q <= 1'b1;
				len_q <= '0;
			end else if (mismatch) begin
				exp_q <= ~exp_q;
				len_q <= span_t'(1);
			end else begin
				len_q <= len_inc;
			end
		end
	end

	// row of sum cells: cell i holds the sum of the last i+1 closed runs
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		if (i == 0) begin : g_head
			lwgf_cell #(.CAP(LEN_CAP)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.push     (cell_push),
				.clear    (cell_clear),
				.run_len  (len_q),
				.prev_sum ('0),
				.sum      (sums[i])
			);
		end else begin : g_body
			lwgf_cell #(.CAP(LEN_CAP)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.push     (cell_push),
				.clear    (cell_clear),
				.run_len  (len_q),
				.prev_sum (sums[i-1]),
				.sum      (sums[i])
			);
		end
	end

	// taps 2k-1, 2k-2, 2k-3 of the row; a tap before the head wraps and reads zero
	assign k   = (max_flips_q > CFG_W'(KMAX)) ? CFG_W'(KMAX) : max_flips_q;
	assign w   = {k, 1'b0};
	assign wd1 = {1'b0, w} - (CFG_W+2)'(1);
	assign wd2 = {1'b0, w} - (CFG_W+2)'(2);
	assign wd3 = {1'b0, w} - (CFG_W+2)'(3);

	always_comb begin
		g1 = '0;
		g2 = '0;
		g3 = '0;
		for (int i = 0; i < NCELL; i++) begin
			if (wd1 == (CFG_W+2)'(i)) begin
				g1 = sums[i];
			end
			if (wd2 == (CFG_W+2)'(i)) begin
				g2 = sums[i];
			end
			if (wd3 == (CFG_W+2)'(i)) begin
				g3 = sums[i];
			end
		end
	end

	// first check closes the open ones run; the second covers the end of
	// stream, where a ones run of one bit or an empty ones run follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1.v1    <= acc && exp_q && (mismatch || in_ch.is_last);
			op_s1.v2    <= acc && in_ch.is_last && (mismatch || !exp_q);
			op_s1.last  <= acc && in_ch.is_last;
			op_s1.zero2 <= (k == '0);
			op_s1.one2  <= mismatch && !exp_q;
			op_s1.lc    <= mismatch ? len_q : len_inc;
			op_s1.lp    <= len_inc;
			op_s1.g1    <= g1;
			op_s1.g2    <= (mismatch && exp_q) ? g3 : g2;
		end
	end

	lwgf_best #(.CAP(LEN_CAP)) u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_s1),
		.push      (res_push),
		.push_data (res_data)
	);

	lwgf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.out_ch    (out_ch)
	);

	// results owed: streams ended but not yet taken from the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({acc && in_ch.is_last, out_ch.valid && out_ch.ready})
				2'b10:   pend_q <= pend_q + OUT_CNT_W'(1);
				2'b01:   pend_q <= pend_q - OUT_CNT_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("more results owed than the output queue holds");

	a_stream_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_ch.is_last |=> exp_q && (len_q == '0))
		else $error("run tracker not back to reset after end of stream");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_CAP)
		else $error("open run length above its cap");

endmodule

// ===== test/tb_longest_ones_with_gap_fills_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_ones_with_gap_fills_top
// Self-checking bench for the longest ones span block: random bit streams of
// varying run structure and flip counts go in, each end-of-stream span is
// predicted bit for bit and compared against the block's output, with random
// stalls on both channels and a long output hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb_longest_ones_with_gap_fills_top;
	import lwgf_pkg::*;

	localparam int          RING_DEPTH = 2 * CFG_MAX + 2;
	localparam int unsigned LEN_CAP    = 1048576;
	localparam int          LIMIT      = 200000;
	localparam int          HOLD_LEN   = 400;
	localparam int          SETTLE     = 8;

	// tracks the run structure of the current stream and the spans still due
	class span_board;
		logic [CFG_W-1:0] flips;
		bit               want_one;
		span_t            open_len;
		span_t            runs[RING_DEPTH];
		int unsigned      wr_ptr;
		span_t            best;
		span_t            spans_due[$];
		int               errors;

		function new();
			flips  = CFG_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			want_one = 1'b1;
			open_len = '0;
			wr_ptr   = 0;
			best     = '0;
			foreach (runs[i]) runs[i] = '0;
		endfunction

		function void push_run(span_t len);
			runs[wr_ptr] = len;
			wr_ptr = (wr_ptr + 1 >= RING_DEPTH) ? 0 : wr_ptr + 1;
		endfunction

		// sum of the last 2k+1 closed runs, capped
		function void check_window();
			int unsigned      k;
			int unsigned      idx;
			longint unsigned  total;
			k     = (flips > CFG_MAX) ? CFG_MAX : flips;
			idx   = wr_ptr;
			total = 0;
			for (int i = 0; i < 2 * k + 1; i++) begin
				idx   = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
				total += runs[idx];
			end
			if (total > LEN_CAP) total = LEN_CAP;
			if (total > best) best = span_t'(total);
		endfunction

		function void close_run();
			push_run(open_len);
			if (want_one) check_window();
		endfunction

		function void note_bit(bit b, bit last);
			if (b == want_one) begin
				if (open_len < LEN_CAP) open_len++;
			end else begin
				close_run();
				want_one = ~want_one;
				open_len = span_t'(1);
			end
			if (last) begin
				close_run();
				// stream ended in zeros: an empty ones run closes it
				if (!want_one) begin
					push_run('0);
					check_window();
				end
				spans_due.insert(spans_due.size(), best);
				clear();
			end
		endfunction

		function void check_span(span_t got);
			span_t want;
			if (spans_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected span %0d", got);
			end else begin
				want = spans_due.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("span mismatch: expected %0d, got %0d", want, got);
				end
			end
		endfunction

		function int pending();
			return spans_due.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	lwgf_in_if  in_ch ();
	lwgf_out_if out_ch ();

	longest_ones_with_gap_fills_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	span_board   board = new();
	bit          in_idle;
	bit          out_idle;
	bit          long_hold_req;
	int          hold_left;
	int          stall_left;
	int unsigned bits_sent;
	int          cycle_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: per-item stalls plus the occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold_req) begin
				hold_left     = HOLD_LEN;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			board.check_span(out_ch.longest_span);
			stall_left = out_idle ? $urandom_range(0, 17) : 0;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_bit(input bit b, input bit last);
		int gap;
		gap = in_idle ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.bit_value <= b;
		in_ch.is_last   <= last;
		do @(posedge clk); while (!in_ch.ready);
		board.note_bit(b, last);
		bits_sent++;
		@(negedge clk);
	endtask

	// bits go out msb first, the lowest bit carries the last flag
	task automatic send_word(input bit [31:0] pat, input int n);
		for (int i = n - 1; i >= 0; i--) send_bit(pat[i], i == 0);
	endtask

	task automatic send_stream(input int nruns, input int maxlen);
		bit b;
		int len;
		b = 1'($urandom_range(0, 1));
		for (int r = 0; r < nruns; r++) begin
			len = $urandom_range(1, maxlen);
			for (int j = 0; j < len; j++) send_bit(b, (r == nruns - 1) && (j == len - 1));
			b = ~b;
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_flips(input logic [CFG_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.flips = v;
		@(negedge clk);
	endtask

	initial begin
		int          phase;
		int          kind;
		int unsigned rand_start;
		int          streams;
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		in_ch.valid     = 1'b0;
		in_ch.bit_value = 1'b0;
		in_ch.is_last   = 1'b0;
		out_ch.ready    = 1'b0;
		in_idle         = 1'b0;
		out_idle        = 1'b0;
		long_hold_req   = 1'b0;
		hold_left       = 0;
		stall_left      = 0;
		bits_sent       = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// flip count still at its reset value
		send_word(32'b1, 1);
		send_word(32'b0, 1);
		send_word(32'b0011010, 7);
		drain();
		write_flips(4'd0);
		send_word(32'b1101110, 7);
		drain();
		write_flips(4'd15);
		send_word(32'b010010001, 9);
		drain();

		phase      = 0;
		streams    = 0;
		rand_start = bits_sent;
		while (bits_sent - rand_start < 500 || streams < 16) begin
			case (phase % 6)
				0:       write_flips(4'd0);
				1:       write_flips(4'd15);
				2:       write_flips(4'd1);
				default: write_flips(CFG_W'($urandom_range(0, 15)));
			endcase
			in_idle  = (phase % 3) != 0;
			out_idle = (phase % 4) != 1;
			if (phase == 2) begin
				// back up the output queue until the input stalls
				in_idle = 1'b0;
				@(posedge clk);
				long_hold_req = 1'b1;
				@(negedge clk);
				for (int s = 0; s < 10; s++) begin
					send_stream($urandom_range(1, 3), 2);
					streams++;
				end
			end
			for (int s = 0; s < 6; s++) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) send_stream($urandom_range(1, 10), $urandom_range(1, 5));
				else if (kind < 9) send_stream($urandom_range(30, 70), 2);
				else send_stream($urandom_range(1, 3), $urandom_range(10, 40));
				streams++;
			end
			drain();
			phase++;
		end

		drain();
		repeat (10) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lwgf_pkg.sv
design/lwgf_in_if.sv
design/lwgf_out_if.sv
design/lwgf_cell.sv
design/lwgf_best.sv
design/lwgf_out_fifo.sv
design/longest_ones_with_gap_fills_top.sv
test/tb_longest_ones_with_gap_fills_top.sv
